// ----- rtl/core/mbp_pkg.sv -----
// ----------------------------------------------------------------------------
// mbp_pkg
// types, codes and digit decode shared by the number parser modules
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam logic [1:0] RX_BIN = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_DEC = 2'd2;
  localparam logic [1:0] RX_HEX = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNEXPECTED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  localparam logic [31:0] VALUE_LIMIT = 32'h0FFF_FFFF;

  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_US    = 8'h5F;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] base;
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        stopped_on_char;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(input logic [1:0] rx, input logic [7:0] c);
    digit_t     d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      diff  = c - CHAR_0;
      d.val = diff[3:0];
      case (rx)
        RX_BIN:  d.ok = (diff <= 8'd1);
        RX_OCT:  d.ok = (diff <= 8'd7);
        default: d.ok = 1'b1;
      endcase
    end else if (rx == RX_HEX && c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      diff  = c - CHAR_LC_A + 8'd10;
      d.val = diff[3:0];
      d.ok  = 1'b1;
    end else if (rx == RX_HEX && c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      diff  = c - CHAR_UC_A + 8'd10;
      d.val = diff[3:0];
      d.ok  = 1'b1;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/mbp_in_reg.sv -----
// ----------------------------------------------------------------------------
// mbp_in_reg
// input register holding one character until the parse stage takes it
// ----------------------------------------------------------------------------
module mbp_in_reg import mbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     s_valid,
  output in_item_t s_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready = !valid_r || take;
  assign s_valid  = valid_r;
  assign s_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/core/mbp_parse.sv -----
// ----------------------------------------------------------------------------
// mbp_parse
// literal state machine and accumulator, one character per step
// ----------------------------------------------------------------------------
module mbp_parse import mbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output result_t  res
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [31:0] accum_r;
  logic [31:0] accum_nxt;
  logic [1:0]  radix_r;
  logic [1:0]  radix_nxt;

  digit_t      dg;
  logic        oct_x;
  logic        bin_us;
  logic [31:0] sum;

  assign dg     = digit_of(radix_r, item.char_code);
  assign oct_x  = (radix_r == RX_OCT) && (item.char_code == CHAR_X);
  assign bin_us = (radix_r == RX_BIN) && (item.char_code == CHAR_US);

  // next accumulator per radix: shift-or for bin, oct and hex, times ten as shift-add for dec
  always_comb begin
    case (radix_r)
      RX_BIN:  sum = {accum_r[30:0], 1'b0} | {28'd0, dg.val};
      RX_OCT:  sum = {accum_r[28:0], 3'd0} | {28'd0, dg.val};
      RX_DEC:  sum = {accum_r[28:0], 3'd0} + {accum_r[30:0], 1'b0} + {28'd0, dg.val};
      default: sum = {accum_r[27:0], 4'd0} | {28'd0, dg.val};
    endcase
  end

  // outputs and datapath
  always_comb begin
    accum_nxt = accum_r;
    radix_nxt = radix_r;
    res       = '0;
    if (item.start_req) begin
      radix_nxt = item.base;
      accum_nxt = '0;
      if (item.last) begin
        res.valid       = 1'b1;
        res.item.status = ST_UNEXPECTED;
      end
    end else begin
      case (phase_r)
        PH_FIRST: begin
          if (oct_x) begin
            radix_nxt = RX_HEX;
            if (item.last) begin
              res.valid       = 1'b1;
              res.item.status = ST_UNEXPECTED;
            end
          end else if (!dg.ok) begin
            res.valid       = 1'b1;
            res.item.status = ST_UNEXPECTED;
          end else begin
            accum_nxt = {28'd0, dg.val};
            if (item.last) begin
              res.valid      = 1'b1;
              res.item.value = {28'd0, dg.val};
            end
          end
        end
        PH_BODY: begin
          if (bin_us) begin
            if (item.last) begin
              res.valid      = 1'b1;
              res.item.value = accum_r;
            end
          end else if (!dg.ok) begin
            res.valid                = 1'b1;
            res.item.value           = accum_r;
            res.item.stopped_on_char = 1'b1;
          end else if (sum > VALUE_LIMIT) begin
            res.valid       = 1'b1;
            res.item.status = ST_OVERFLOW;
          end else begin
            accum_nxt = sum;
            if (item.last) begin
              res.valid      = 1'b1;
              res.item.value = sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    if (res.valid) begin
      phase_nxt = PH_IDLE;
    end else if (item.start_req) begin
      phase_nxt = PH_FIRST;
    end else begin
      case (phase_r)
        PH_FIRST: phase_nxt = oct_x ? PH_FIRST : PH_BODY;
        PH_BODY:  phase_nxt = PH_BODY;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= '0;
      radix_r <= RX_BIN;
    end else if (step) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      radix_r <= radix_nxt;
    end
  end

endmodule

// ----- rtl/core/mbp_out_reg.sv -----
// ----------------------------------------------------------------------------
// mbp_out_reg
// result register holding one result until its transfer
// ----------------------------------------------------------------------------
module mbp_out_reg import mbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

endmodule

// ----- rtl/core/multi_base_number_parser.sv -----
// path: input transfer to result valid through the input register and the result register
// throughput: one character per cycle unless output backpressure stalls the parse stage,
// which updates accumulator and phase once per character
// characters that end no literal produce no result transfer
// reset: synchronous active-low rst_n clears valids, phase, radix and accumulator
// ----------------------------------------------------------------------------
// multi_base_number_parser
// parses binary, octal, decimal and hex integer literals from a character stream
// ----------------------------------------------------------------------------
module multi_base_number_parser import mbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic     s_valid;
  in_item_t s_item;
  logic     step;
  result_t  res;

  assign step = s_valid && (!out_valid || out_ready);

  mbp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  mbp_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s_item),
    .res   (res)
  );

  mbp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res.valid),
    .load_item (res.item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_ok_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_OK) |-> (out_item.value <= VALUE_LIMIT))
    else $error("ok result above value limit");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |->
      (out_item.value == 32'd0 && !out_item.stopped_on_char))
    else $error("error result carries value or stop flag");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK || out_item.status == ST_UNEXPECTED ||
                   out_item.status == ST_OVERFLOW))
    else $error("unused status code");

endmodule

// ----- tb/multi_base_number_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_base_number_parser_tb
// feeds character streams into the number parser and checks every literal
// result against a cycle-free model of the parse, under random idling on
// both channels, with a short directed opening and a random tail
// ----------------------------------------------------------------------------
module multi_base_number_parser_tb;
  import mbp_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int TAIL_ITEMS   = 120;
  localparam int SETTLE       = 4;
  localparam int END_CYCLES   = 10;
  localparam int QUIET_LIMIT  = 500;
  localparam int MAX_REPORTS  = 200;

  typedef struct {
    in_item_t item;
    bit       drain;
  } char_slot_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  char_slot_t char_queue[$];
  out_item_t  lit_expected[$];
  bit         drain_next;

  // parse state
  logic [31:0] pm_accum;
  phase_t      pm_phase;
  logic [1:0]  pm_radix;

  int chars_total;
  int chars_sent;
  int chars_accepted;
  int drv_gap, drv_calm, drain_wait;
  int rcv_stall, rcv_calm;
  int quiet_cycles;
  int errors, reports;
  int cnt_ok, cnt_stop, cnt_bad, cnt_ovf;
  out_item_t  lit_res;
  out_item_t  lit_exp;
  in_item_t   next_item;
  logic       next_valid;
  char_slot_t next_slot;

  wire calm_tail = (chars_sent + TAIL_ITEMS >= chars_total);

  multi_base_number_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int char_digit(input logic [1:0] rx, input logic [7:0] c);
    int dv;
    dv = -1;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      dv = int'(c - CHAR_0);
      if (rx == RX_BIN && dv > 1) dv = -1;
      if (rx == RX_OCT && dv > 7) dv = -1;
    end else if (rx == RX_HEX && c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      dv = int'(c - CHAR_LC_A) + 10;
    end else if (rx == RX_HEX && c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      dv = int'(c - CHAR_UC_A) + 10;
    end
    return dv;
  endfunction

  // advances the parse by one character; returns 1 when a literal ends
  function automatic bit parse_char(input in_item_t ch, output out_item_t res);
    bit done;
    int dv;
    done = 1'b0;
    res  = '0;
    if (ch.start_req) begin
      pm_radix = ch.base;
      pm_accum = '0;
      pm_phase = PH_FIRST;
      if (ch.last) begin
        res.status = ST_UNEXPECTED;
        done = 1'b1;
      end
    end else begin
      case (pm_phase)
        PH_FIRST: begin
          if (pm_radix == RX_OCT && ch.char_code == CHAR_X) begin
            pm_radix = RX_HEX;
            if (ch.last) begin
              res.status = ST_UNEXPECTED;
              done = 1'b1;
            end
          end else begin
            dv = char_digit(pm_radix, ch.char_code);
            if (dv < 0) begin
              res.status = ST_UNEXPECTED;
              done = 1'b1;
            end else begin
              pm_accum = dv;
              pm_phase = PH_BODY;
              if (ch.last) begin
                res.value = pm_accum;
                done = 1'b1;
              end
            end
          end
        end
        PH_BODY: begin
          if (pm_radix == RX_BIN && ch.char_code == CHAR_US) begin
            if (ch.last) begin
              res.value = pm_accum;
              done = 1'b1;
            end
          end else begin
            dv = char_digit(pm_radix, ch.char_code);
            if (dv < 0) begin
              res.value = pm_accum;
              res.stopped_on_char = 1'b1;
              done = 1'b1;
            end else begin
              case (pm_radix)
                RX_BIN:  pm_accum = (pm_accum << 1) | dv;
                RX_OCT:  pm_accum = (pm_accum << 3) | dv;
                RX_DEC:  pm_accum = pm_accum * 32'd10 + dv;
                default: pm_accum = (pm_accum << 4) | dv;
              endcase
              if (pm_accum > VALUE_LIMIT) begin
                res.status = ST_OVERFLOW;
                done = 1'b1;
              end else if (ch.last) begin
                res.value = pm_accum;
                done = 1'b1;
              end
            end
          end
        end
        default: pm_phase = PH_IDLE;
      endcase
    end
    if (done) pm_phase = PH_IDLE;
    return done;
  endfunction

  task automatic push_char(input logic s, input logic [1:0] rx, input logic [7:0] c,
                           input logic l);
    char_slot_t slot;
    slot.item.start_req = s;
    slot.item.base      = rx;
    slot.item.char_code = c;
    slot.item.last      = l;
    slot.drain          = drain_next;
    drain_next          = 1'b0;
    char_queue.push_back(slot);
  endtask

  task automatic queue_literal(input logic [1:0] rx, input string txt, input bit end_last);
    push_char(1'b1, rx, CHAR_0, 1'b0);
    for (int k = 0; k < txt.len(); k++)
      push_char(1'b0, 2'($urandom_range(0, 3)), txt[k], end_last && (k == txt.len() - 1));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_char(in_item, lit_res)) lit_expected.push_back(lit_res);
        chars_accepted++;
      end
      if (!in_valid || in_ready) begin
        next_valid = 1'b0;
        next_item  = in_item;
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (char_queue.size() > 0) begin
          if (char_queue[0].drain && (lit_expected.size() > 0 || drain_wait < SETTLE)) begin
            if (lit_expected.size() > 0) drain_wait = 0;
            else drain_wait++;
          end else if (!calm_tail && drv_calm == 0 && $urandom_range(0, 5) == 0) begin
            drv_gap = $urandom_range(1, 11) - 1;
          end else begin
            next_slot  = char_queue.pop_front();
            next_valid = 1'b1;
            next_item  = next_slot.item;
            chars_sent++;
            if (drv_calm > 0) drv_calm--;
            else if ($urandom_range(0, 39) == 0) drv_calm = $urandom_range(20, 60);
          end
        end
        in_valid <= next_valid;
        in_item  <= next_item;
      end
    end
  end

  // monitor and result checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lit_expected.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h/%0d/%0d", $time,
                   out_item.value, out_item.status, out_item.stopped_on_char);
        end else begin
          lit_exp = lit_expected.pop_front();
          if (lit_exp.status == ST_OVERFLOW) cnt_ovf++;
          else if (lit_exp.status == ST_UNEXPECTED) cnt_bad++;
          else cnt_ok++;
          if (lit_exp.stopped_on_char) cnt_stop++;
          if (out_item.value !== lit_exp.value) begin
            errors++;
            if (reports++ < MAX_REPORTS)
              $display("%0t value mismatch: expected %h actual %h", $time,
                       lit_exp.value, out_item.value);
          end
          if (out_item.status !== lit_exp.status) begin
            errors++;
            if (reports++ < MAX_REPORTS)
              $display("%0t status mismatch: expected %0d actual %0d", $time,
                       lit_exp.status, out_item.status);
          end
          if (out_item.stopped_on_char !== lit_exp.stopped_on_char) begin
            errors++;
            if (reports++ < MAX_REPORTS)
              $display("%0t stopped_on_char mismatch: expected %0d actual %0d", $time,
                       lit_exp.stopped_on_char, out_item.stopped_on_char);
          end
        end
      end
      if (rcv_stall > 0) begin
        rcv_stall--;
        out_ready <= 1'b0;
      end else if (!calm_tail && rcv_calm == 0 && $urandom_range(0, 7) == 0) begin
        rcv_stall = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rcv_calm > 0) rcv_calm--;
        else if ($urandom_range(0, 49) == 0) rcv_calm = $urandom_range(20, 80);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          directed;
    int          n;
    int          end_mode;
    int          r;
    int          hv;
    bit          drain_done;
    logic [1:0]  rx;
    logic [1:0]  cur;
    logic [7:0]  dc;

    drain_done = 1'b0;
    pm_accum   = '0;
    pm_phase   = PH_IDLE;
    pm_radix   = RX_BIN;

    // directed literals
    push_char(1'b0, RX_HEX, 8'hFF, 1'b0);           // character outside any literal
    push_char(1'b1, RX_BIN, CHAR_0, 1'b1);          // empty literal
    queue_literal(RX_HEX, "aF", 1'b0);
    push_char(1'b0, RX_DEC, 8'h00, 1'b0);           // ends on a non-digit
    queue_literal(RX_OCT, "x", 1'b1);               // hex switch with nothing after
    queue_literal(RX_OCT, "xx", 1'b0);              // second x is a bad first digit
    queue_literal(RX_BIN, "1_0_", 1'b1);            // underscores skipped, last on one
    queue_literal(RX_BIN, "_", 1'b0);               // underscore cannot lead
    queue_literal(RX_DEC, "7", 1'b0);               // dropped by the restart below
    queue_literal(RX_HEX, "FFFFFFFF", 1'b0);        // overflow
    directed = char_queue.size();

    while (char_queue.size() < directed + RANDOM_ITEMS) begin
      if (!drain_done && char_queue.size() >= directed + RANDOM_ITEMS / 2) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      rx = 2'($urandom_range(0, 3));
      if (r < 12) begin
        push_char(1'($urandom_range(0, 1)), rx, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (r < 17) begin
        push_char(1'b1, rx, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_char(1'b1, rx, 8'($urandom_range(0, 255)), 1'b0);
        cur = rx;
        if (rx == RX_OCT && $urandom_range(0, 2) == 0) begin
          push_char(1'b0, 2'($urandom_range(0, 3)), CHAR_X, 1'b0);
          cur = RX_HEX;
        end
        r = $urandom_range(0, 19);
        if (r < 14) n = $urandom_range(1, 6);
        else if (r < 19) n = $urandom_range(7, 12);
        else n = $urandom_range(13, 34);
        end_mode = $urandom_range(0, 9);
        if (end_mode == 9) n = 0;
        for (int k = 0; k < n; k++) begin
          if (cur == RX_BIN && k > 0 && $urandom_range(0, 4) == 0)
            push_char(1'b0, 2'($urandom_range(0, 3)), CHAR_US, 1'b0);
          case (cur)
            RX_BIN:  dc = CHAR_0 + 8'($urandom_range(0, 1));
            RX_OCT:  dc = CHAR_0 + 8'($urandom_range(0, 7));
            RX_DEC:  dc = CHAR_0 + 8'($urandom_range(0, 9));
            default: begin
              hv = $urandom_range(0, 15);
              if (hv < 10) dc = CHAR_0 + 8'(hv);
              else if ($urandom_range(0, 1) == 0) dc = CHAR_LC_A + 8'(hv - 10);
              else dc = CHAR_UC_A + 8'(hv - 10);
            end
          endcase
          push_char(1'b0, 2'($urandom_range(0, 3)), dc, (k == n - 1) && (end_mode < 5));
        end
        if (end_mode >= 5)
          push_char(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
    end
    chars_total = char_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_accepted < chars_total || lit_expected.size() > 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (lit_expected.size() > 0) begin
      errors++;
      $display("%0t %0d results still expected, first %h/%0d/%0d, actual none", $time,
               lit_expected.size(), lit_expected[0].value, lit_expected[0].status,
               lit_expected[0].stopped_on_char);
    end
    $display("characters sent: %0d (%0d directed), literals ended: %0d", chars_total,
             directed, cnt_ok + cnt_bad + cnt_ovf);
    $display("literal outcomes: %0d ok (%0d stopped on a character), %0d bad, %0d overflow",
             cnt_ok, cnt_stop, cnt_bad, cnt_ovf);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- multi_base_number_parser.f -----
rtl/core/mbp_pkg.sv
rtl/core/mbp_in_reg.sv
rtl/core/mbp_parse.sv
rtl/core/mbp_out_reg.sv
rtl/core/multi_base_number_parser.sv
tb/multi_base_number_parser_tb.sv
